@@ rtl/rgtc_pkg.sv @@
// ----------------------------------------------------------------------------
// rgtc_pkg: shared types and constants of the replay-guarded tag check
// Status codes, SHA-256 constants, the front-to-back work record and the
// compression-round helper.
// ----------------------------------------------------------------------------
package rgtc_pkg;

   localparam int unsigned TagBytesDefault = 8;
   localparam int unsigned IdWidth  = 32;
   localparam int unsigned TagWidth = 64;
   localparam int unsigned LenWidth = 16;
   localparam int unsigned MsgBytes = 20;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNAUTH    = 2'd1,
      STATUS_TOO_SHORT = 2'd2
   } status_type;

   localparam logic [0:0] CSR_PASSCODE = 1'b0;

   // Work handed from the front end to the back end.
   typedef struct packed {
      logic                hash_en;
      logic [IdWidth-1:0]  id;
      logic [TagWidth-1:0] rx_tag;
      logic [LenWidth-1:0] len;
      logic [31:0]         passcode;
   } work_type;

   typedef logic [31:0] word_type;

   function automatic word_type sha_k(input logic [5:0] idx);
      word_type k;
      unique case (idx)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   localparam word_type H0 = 32'h6a09e667;
   localparam word_type H1 = 32'hbb67ae85;
   localparam word_type H2 = 32'h3c6ef372;
   localparam word_type H3 = 32'ha54ff53a;
   localparam word_type H4 = 32'h510e527f;
   localparam word_type H5 = 32'h9b05688c;
   localparam word_type H6 = 32'h1f83d9ab;
   localparam word_type H7 = 32'h5be0cd19;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ rtl/rgtc_if.sv @@
// ----------------------------------------------------------------------------
// rgtc_if: valid/ready channel interfaces
// One interface for command items and one for result items.
// ----------------------------------------------------------------------------
interface rgtc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] command_id;
   logic [63:0] received_tag;
   logic [15:0] payload_length;
   modport source (output valid, command_id, received_tag, payload_length, input ready);
   modport sink   (input valid, command_id, received_tag, payload_length, output ready);
endinterface

interface rgtc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] remaining_length;
   logic [63:0] computed_tag;
   modport source (output valid, status, remaining_length, computed_tag, input ready);
   modport sink   (input valid, status, remaining_length, computed_tag, output ready);
endinterface

@@ rtl/replay_guarded_tag_check.sv @@
// ----------------------------------------------------------------------------
// replay_guarded_tag_check: command authentication with replay guard
// An item whose id does not rise goes from the engine's idle state straight to
// the result state; an item with a rising id first has its id and passcode
// converted to decimal digits by repeated subtraction, then runs the 64-round
// SHA-256 loop, one round per cycle. Intake and id check run ahead through a
// two-entry queue.
// ----------------------------------------------------------------------------
module replay_guarded_tag_check #(
   parameter int unsigned TAG_BYTES = rgtc_pkg::TagBytesDefault
) (
   input  logic        clock,
   input  logic        reset,
   rgtc_req_if.sink    req,
   rgtc_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0] passcode_ff;
   logic        fw_valid, fw_ready, bw_valid, bw_ready;
   rgtc_pkg::work_type fw_data, bw_data;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:1] == rgtc_pkg::CSR_PASSCODE) ? passcode_ff : 32'd0;

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         passcode_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[1:1] == rgtc_pkg::CSR_PASSCODE) begin
         passcode_ff <= csr_pwdata;
      end
   end

   rgtc_front u_front (
      .clock, .reset, .req, .passcode(passcode_ff),
      .work_valid(fw_valid), .work_ready(fw_ready), .work(fw_data)
   );

   rgtc_queue u_queue (
      .clock, .reset, .in_valid(fw_valid), .in_ready(fw_ready), .in_data(fw_data),
      .out_valid(bw_valid), .out_ready(bw_ready), .out_data(bw_data)
   );

   rgtc_back #(.TAG_BYTES(TAG_BYTES)) u_back (
      .clock, .reset, .work_valid(bw_valid), .work_ready(bw_ready), .work(bw_data), .rsp
   );

endmodule

@@ rtl/rgtc_front.sv @@
// ----------------------------------------------------------------------------
// rgtc_front: command intake
// Accepts items, applies the replay check on the stored last id and hands a
// work record with the passcode snapshot to the queue.
// ----------------------------------------------------------------------------
module rgtc_front (
   input  logic                  clock,
   input  logic                  reset,
   rgtc_req_if.sink              req,
   input  logic [31:0]           passcode,
   output logic                  work_valid,
   input  logic                  work_ready,
   output rgtc_pkg::work_type    work
);

   logic [31:0] last_id_ff, last_id_in;
   logic        take;

   assign req.ready  = work_ready;
   assign work_valid = req.valid;
   assign take       = req.valid & work_ready;

   // classify: hash only on a strictly rising id
   always_comb begin
      work.hash_en  = req.command_id > last_id_ff;
      work.id       = req.command_id;
      work.rx_tag   = req.received_tag;
      work.len      = req.payload_length;
      work.passcode = passcode;
      last_id_in    = take ? req.command_id : last_id_ff;
   end

   // hold last id
   always_ff @(posedge clock) begin
      if (reset) begin
         last_id_ff <= '0;
      end else begin
         last_id_ff <= last_id_in;
      end
   end

endmodule

@@ rtl/rgtc_queue.sv @@
// ----------------------------------------------------------------------------
// rgtc_queue: two-entry work queue
// Decouples the intake from the hash engine.
// ----------------------------------------------------------------------------
module rgtc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rgtc_pkg::work_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rgtc_pkg::work_type out_data
);

   rgtc_pkg::work_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   // store entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

@@ rtl/rgtc_back.sv @@
// ----------------------------------------------------------------------------
// rgtc_back: decimal text and SHA-256 engine
// Converts id and passcode of a rising-id item to digits by repeated
// subtraction, packs the message block, runs 64 rounds and issues the
// result; an item with a non-rising id goes straight to the result.
module rgtc_back #(
   parameter int unsigned TAG_BYTES = rgtc_pkg::TagBytesDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_valid,
   output logic               work_ready,
   input  rgtc_pkg::work_type work,
   rgtc_rsp_if.source         rsp
);

   localparam int unsigned CmpBytes = (TAG_BYTES < 8) ? TAG_BYTES : 8;
   localparam logic [63:0] CmpMask  = ~(64'hffff_ffff_ffff_ffff >> (8 * CmpBytes));
   localparam logic [15:0] TagLen   = 16'(TAG_BYTES);

   typedef enum logic [2:0] {
      IDLE, CONV, PACK, ROUND, FINISH, SEND
   } state_type;

   state_type   state_ff;
   rgtc_pkg::work_type job_ff;
   logic [31:0] val_ff;         // number being split into digits
   logic [3:0]  pos_ff;         // power-of-ten position, 9 down to 0
   logic [3:0]  dig_ff;
   logic        seen_ff;        // leading nonzero digit seen
   logic        second_ff;      // converting passcode
   logic [159:0] msg_ff;        // up to 20 text bytes, left aligned
   logic [4:0]  nbytes_ff;
   logic [31:0] w_ff [16];
   logic [5:0]  rnd_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic [63:0] last_tag_ff;
   logic [1:0]  status_ff;
   logic [15:0] rem_ff;

   // power of ten for the current digit position
   logic [31:0] pow10;
   always_comb begin
      case (pos_ff)
         4'd9: pow10 = 32'd1000000000;
         4'd8: pow10 = 32'd100000000;
         4'd7: pow10 = 32'd10000000;
         4'd6: pow10 = 32'd1000000;
         4'd5: pow10 = 32'd100000;
         4'd4: pow10 = 32'd10000;
         4'd3: pow10 = 32'd1000;
         4'd2: pow10 = 32'd100;
         4'd1: pow10 = 32'd10;
         default: pow10 = 32'd1;
      endcase
   end

   logic        ge;
   logic        emit;
   logic        id_done;
   logic [7:0]  ch;
   assign ge      = val_ff >= pow10;
   assign ch      = {4'h3, dig_ff};
   assign emit    = seen_ff | (dig_ff != 4'd0) | (pos_ff == 4'd0);
   assign id_done = (pos_ff == 4'd0) & ~second_ff;

   // round datapath
   logic [31:0] t1, t2, s0, s1, wn, kw;
   always_comb begin
      kw = rgtc_pkg::sha_k(rnd_ff) + w_ff[0];
      t1 = h_ff + (rgtc_pkg::rotr(e_ff, 6) ^ rgtc_pkg::rotr(e_ff, 11) ^
           rgtc_pkg::rotr(e_ff, 25)) + ((e_ff & f_ff) ^ (~e_ff & g_ff)) + kw;
      t2 = (rgtc_pkg::rotr(a_ff, 2) ^ rgtc_pkg::rotr(a_ff, 13) ^
           rgtc_pkg::rotr(a_ff, 22)) + ((a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff));
      s0 = rgtc_pkg::rotr(w_ff[1], 7) ^ rgtc_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rgtc_pkg::rotr(w_ff[14], 17) ^ rgtc_pkg::rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
   end

   // padded block of the collected text
   logic [511:0] blk;
   always_comb begin
      blk = '0;
      blk[511 -: 160] = msg_ff;
      blk[511 - 8 * nbytes_ff -: 8] = 8'h80;
      blk[63:0] = {56'd0, nbytes_ff, 3'd0};
   end

   logic [63:0] tag_new;
   assign tag_new = {a_ff + rgtc_pkg::H0, b_ff + rgtc_pkg::H1};

   assign work_ready       = state_ff == IDLE;
   assign rsp.valid        = state_ff == SEND;
   assign rsp.status       = status_ff;
   assign rsp.remaining_length = rem_ff;
   assign rsp.computed_tag = last_tag_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         last_tag_ff <= '0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (work_valid) begin
                  job_ff    <= work;
                  val_ff    <= work.id;
                  pos_ff    <= 4'd9;
                  dig_ff    <= 4'd0;
                  seen_ff   <= 1'b0;
                  second_ff <= 1'b0;
                  msg_ff    <= '0;
                  nbytes_ff <= '0;
                  status_ff <= rgtc_pkg::STATUS_UNAUTH;
                  rem_ff    <= work.len;
                  state_ff  <= work.hash_en ? CONV : SEND;
               end
            end
            CONV: begin
               // subtract one power of ten per cycle, emit digit when done
               if (ge) begin
                  val_ff <= val_ff - pow10;
                  dig_ff <= dig_ff + 4'd1;
               end else begin
                  if (emit) begin
                     msg_ff[159 - 8 * nbytes_ff -: 8] <= ch;
                     nbytes_ff <= nbytes_ff + 5'd1;
                  end
                  // clear the leading-digit flag when the passcode starts
                  seen_ff <= (seen_ff | emit) & ~id_done;
                  dig_ff <= 4'd0;
                  if (pos_ff == 4'd0) begin
                     if (second_ff) begin
                        state_ff <= PACK;
                     end else begin
                        second_ff <= 1'b1;
                        val_ff    <= job_ff.passcode;
                        pos_ff    <= 4'd9;
                     end
                  end else begin
                     pos_ff <= pos_ff - 4'd1;
                  end
               end
            end
            PACK: begin
               for (int i = 0; i < 16; i++) begin
                  w_ff[i] <= blk[511 - 32 * i -: 32];
               end
               a_ff <= rgtc_pkg::H0; b_ff <= rgtc_pkg::H1;
               c_ff <= rgtc_pkg::H2; d_ff <= rgtc_pkg::H3;
               e_ff <= rgtc_pkg::H4; f_ff <= rgtc_pkg::H5;
               g_ff <= rgtc_pkg::H6; h_ff <= rgtc_pkg::H7;
               rnd_ff   <= '0;
               state_ff <= ROUND;
            end
            ROUND: begin
               h_ff <= g_ff; g_ff <= f_ff; f_ff <= e_ff; e_ff <= d_ff + t1;
               d_ff <= c_ff; c_ff <= b_ff; b_ff <= a_ff; a_ff <= t1 + t2;
               for (int i = 0; i < 15; i++) begin
                  w_ff[i] <= w_ff[i + 1];
               end
               w_ff[15] <= wn;
               rnd_ff   <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) begin
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               last_tag_ff <= tag_new;
               if (job_ff.len < TagLen) begin
                  status_ff <= rgtc_pkg::STATUS_TOO_SHORT;
               end else if ((tag_new & CmpMask) == (job_ff.rx_tag & CmpMask)) begin
                  status_ff <= rgtc_pkg::STATUS_OK;
                  rem_ff    <= job_ff.len - TagLen;
               end
               state_ff <= SEND;
            end
            SEND: begin
               if (rsp.ready) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

@@ rtl/rgtc_checker.sv @@
// ----------------------------------------------------------------------------
// rgtc_checker: port-level checks of the tag check block
// Watches result status codes, length and handshake stability.
// ----------------------------------------------------------------------------
module rgtc_checker #(
   parameter int unsigned TAG_BYTES = rgtc_pkg::TagBytesDefault
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_remaining_length,
   input logic [63:0] rsp_computed_tag
);

   localparam logic [15:0] TagLen = 16'(TAG_BYTES);

   // status code is never the unused code
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= rgtc_pkg::STATUS_TOO_SHORT) else $error("bad status");

   // a stalled result stays valid and keeps its tag
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_computed_tag))
      else $error("result dropped");

   // too short never reports a long length
   a_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rgtc_pkg::STATUS_TOO_SHORT |->
      rsp_remaining_length < TagLen)
      else $error("short length");

endmodule

bind replay_guarded_tag_check rgtc_checker #(.TAG_BYTES(TAG_BYTES)) u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_remaining_length(rsp.remaining_length),
   .rsp_computed_tag(rsp.computed_tag)
);
